// ===== rtl/pws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pws_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned WEIGHT_W        = 8;
  localparam int unsigned WIDTH_W         = 16;
  localparam int unsigned DENOM_W         = WEIGHT_W + 1;
  localparam int unsigned PROD_W          = WEIGHT_W + WIDTH_W;
  localparam int unsigned NUM_W           = PROD_W + 1;
  localparam int unsigned ADDR_W          = 4;
  localparam int unsigned DATA_W          = 32;

  localparam logic [WEIGHT_W-1:0] OLD_WEIGHT_RST = 8'd1;
  localparam logic [WEIGHT_W-1:0] NEW_WEIGHT_RST = 8'd1;
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH_RST  = 16'd800;
  localparam logic [WIDTH_W-1:0]  MAX_WIDTH_RST  = 16'd2200;

  localparam logic [1:0] REG_OLD_WEIGHT = 2'd0;
  localparam logic [1:0] REG_NEW_WEIGHT = 2'd1;
  localparam logic [1:0] REG_MIN_WIDTH  = 2'd2;
  localparam logic [1:0] REG_MAX_WIDTH  = 2'd3;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   dividend;
    logic [DENOM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [WIDTH_W-1:0] quotient;
  } div_resp_t;

endpackage

`default_nettype wire

// ===== rtl/pws_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in WIDTH_W bits, so the top bits of the dividend seed the remainder.
module pws_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pws_pkg::div_req_t req_i,
  output pws_pkg::div_resp_t resp_o
);

  localparam int unsigned QW   = pws_pkg::WIDTH_W;
  localparam int unsigned DW   = pws_pkg::DENOM_W;
  localparam int unsigned CNTW = $clog2(QW);

  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   div_q, div_d;
  logic [QW-1:0]   sh_q, sh_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW+1:0]   trial;

  assign trial = {1'b0, rem_q, sh_q[QW-1]} - {2'b00, div_q};

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.dividend[pws_pkg::NUM_W-1:QW];
      sh_d   = req_i.dividend[QW-1:0];
      div_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[DW+1]) begin
        rem_d = {rem_q[DW-2:0], sh_q[QW-1]};
        sh_d  = {sh_q[QW-2:0], 1'b0};
      end else begin
        rem_d = trial[DW-1:0];
        sh_d  = {sh_q[QW-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {CNTW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    sh_q  <= sh_d;
  end

  assign resp_o.done     = done_q;
  assign resp_o.quotient = sh_q;

endmodule

`default_nettype wire

// ===== rtl/pulse_width_smoother_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pulse width smoother: one pin sample per request, one result per request.
// A sample that does not end an accepted high pulse passes from acceptance
// through the done state to the result. A sample that ends an accepted pulse
// takes the long path: two passes through a shared 8x16 multiplier build the
// weighted sum, then a restoring divider retires one quotient bit per cycle. The
// input stalls from acceptance until the result is in the output register;
// a result waiting there does not block the next sample.
module pulse_width_smoother_core #(
  parameter int unsigned TIMER_WIDTH = pws_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         pin_level_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [pws_pkg::WIDTH_W-1:0]       smoothed_width_o,
  output logic                              updated_o,
  output logic                              rejected_o,
  input  wire logic                         psel_i,
  input  wire logic                         penable_i,
  input  wire logic                         pwrite_i,
  input  wire logic [pws_pkg::ADDR_W-1:0]   paddr_i,
  input  wire logic [pws_pkg::DATA_W-1:0]   pwdata_i,
  output logic [pws_pkg::DATA_W-1:0]        prdata_o,
  output logic                              pready_o
);

  localparam int unsigned WW   = pws_pkg::WEIGHT_W;
  localparam int unsigned AW   = pws_pkg::WIDTH_W;
  localparam int unsigned CMPW = (TIMER_WIDTH > AW) ? TIMER_WIDTH : AW;
  localparam logic [TIMER_WIDTH-1:0] TICK_MAX = {TIMER_WIDTH{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_MUL_OLD = 5'b00010,
    ST_MUL_NEW = 5'b00100,
    ST_DIV     = 5'b01000,
    ST_DONE    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [WW-1:0] old_weight_q, new_weight_q;
  logic [AW-1:0] min_width_q, max_width_q;

  logic                   last_level_q, last_level_d;
  logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [AW-1:0]          avg_q, avg_d;
  logic [AW-1:0]          width_q, width_d;
  logic [pws_pkg::PROD_W-1:0] acc_q, acc_d;
  logic                   upd_q, upd_d, rej_q, rej_d;

  logic                   out_valid_q, out_valid_d;
  logic [AW-1:0]          out_width_q, out_width_d;
  logic                   out_upd_q, out_upd_d, out_rej_q, out_rej_d;

  logic                   cfg_wr;
  logic                   accept;
  logic [TIMER_WIDTH-1:0] ticks_inc;
  logic [CMPW-1:0]        ticks_ext;
  logic                   edge_seen, falling, in_window;
  logic [pws_pkg::DENOM_W-1:0] denom;
  logic [WW-1:0]          mul_a;
  logic [AW-1:0]          mul_b;
  logic [pws_pkg::PROD_W-1:0]  prod;
  logic                   out_free;

  pws_pkg::div_req_t  div_req;
  pws_pkg::div_resp_t div_resp;

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_weight_q <= pws_pkg::OLD_WEIGHT_RST;
      new_weight_q <= pws_pkg::NEW_WEIGHT_RST;
      min_width_q  <= pws_pkg::MIN_WIDTH_RST;
      max_width_q  <= pws_pkg::MAX_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr_i[3:2])
        pws_pkg::REG_OLD_WEIGHT: old_weight_q <= pwdata_i[WW-1:0];
        pws_pkg::REG_NEW_WEIGHT: new_weight_q <= pwdata_i[WW-1:0];
        pws_pkg::REG_MIN_WIDTH:  min_width_q  <= pwdata_i[AW-1:0];
        pws_pkg::REG_MAX_WIDTH:  max_width_q  <= pwdata_i[AW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[3:2])
      pws_pkg::REG_OLD_WEIGHT: prdata_o = {{(pws_pkg::DATA_W-WW){1'b0}}, old_weight_q};
      pws_pkg::REG_NEW_WEIGHT: prdata_o = {{(pws_pkg::DATA_W-WW){1'b0}}, new_weight_q};
      pws_pkg::REG_MIN_WIDTH:  prdata_o = {{(pws_pkg::DATA_W-AW){1'b0}}, min_width_q};
      pws_pkg::REG_MAX_WIDTH:  prdata_o = {{(pws_pkg::DATA_W-AW){1'b0}}, max_width_q};
      default:                 prdata_o = '0;
    endcase
  end

  // sample decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign ticks_inc  = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign ticks_ext  = CMPW'(ticks_inc);
  assign edge_seen  = pin_level_i ^ last_level_q;
  assign falling    = edge_seen & ~pin_level_i;
  assign in_window  = (ticks_ext > CMPW'(min_width_q)) & (ticks_ext < CMPW'(max_width_q));
  assign denom      = {1'b0, old_weight_q} + {1'b0, new_weight_q};

  // shared multiplier
  assign mul_a = (state_q == ST_MUL_OLD) ? old_weight_q : new_weight_q;
  assign mul_b = (state_q == ST_MUL_OLD) ? avg_q : width_q;
  assign prod  = mul_a * mul_b;

  assign div_req.start    = (state_q == ST_MUL_NEW);
  assign div_req.dividend = {1'b0, acc_q} + {1'b0, prod};
  assign div_req.divisor  = denom;

  pws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d      = state_q;
    last_level_d = last_level_q;
    elapsed_d    = elapsed_q;
    avg_d        = avg_q;
    width_d      = width_q;
    acc_d        = acc_q;
    upd_d        = upd_q;
    rej_d        = rej_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_width_d  = out_width_q;
    out_upd_d    = out_upd_q;
    out_rej_d    = out_rej_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_level_d = pin_level_i;
          elapsed_d    = edge_seen ? '0 : ticks_inc;
          width_d      = ticks_ext[AW-1:0];
          upd_d        = 1'b0;
          rej_d        = 1'b0;
          if (falling && in_window && (denom != '0)) begin
            state_d = ST_MUL_OLD;
          end else begin
            rej_d   = falling;
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL_OLD: begin
        acc_d   = prod;
        state_d = ST_MUL_NEW;
      end
      ST_MUL_NEW: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_resp.done) begin
          avg_d   = div_resp.quotient;
          upd_d   = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_width_d = avg_q;
          out_upd_d   = upd_q;
          out_rej_d   = rej_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_level_q <= 1'b0;
      elapsed_q    <= '0;
      avg_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_level_q <= last_level_d;
      elapsed_q    <= elapsed_d;
      avg_q        <= avg_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q     <= width_d;
    acc_q       <= acc_d;
    upd_q       <= upd_d;
    rej_q       <= rej_d;
    out_width_q <= out_width_d;
    out_upd_q   <= out_upd_d;
    out_rej_q   <= out_rej_d;
  end

  assign out_valid_o      = out_valid_q;
  assign smoothed_width_o = out_width_q;
  assign updated_o        = out_upd_q;
  assign rejected_o       = out_rej_q;

endmodule

`default_nettype wire

// ===== rtl/pws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pws_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [pws_pkg::WIDTH_W-1:0]  smoothed_width_o,
  input wire logic                         updated_o,
  input wire logic                         rejected_o
);

  // one request in flight: the input stalls straight after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted a second request while busy");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(updated_o && rejected_o))
    else $error("result flagged both updated and rejected");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(smoothed_width_o) && $stable(updated_o)
       && $stable(rejected_o)))
    else $error("stalled result changed");

endmodule

bind pulse_width_smoother_core pws_checker u_pws_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .smoothed_width_o (smoothed_width_o),
  .updated_o        (updated_o),
  .rejected_o       (rejected_o)
);

`default_nettype wire
